/* hdl/fla_pkg.sv */
`timescale 1ns / 1ps

package fla_pkg;

  // port field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned ST_W    = 2;

  // register port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [CNT_W-1:0] POOL_SIZE_RST = 11'd1024;
  localparam logic REG_POOL_SIZE = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_FIND   = 2'd2,
    OP_REINIT = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_BAD_FREE  = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_EXEC  = 2'd1,
    S_SCAN  = 2'd2,
    S_SDONE = 2'd3
  } state_e;

  // used-bit ram read address source
  typedef enum logic [1:0] {
    RD_INPUT = 2'd0,
    RD_HELD  = 2'd1,
    RD_NEXT  = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic    accept;
    logic    commit;
    logic    scan_run;
    logic    load_srch;
    rd_sel_e rd_sel;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic scan_done;
  } sts_t;

endpackage

/* hdl/free_list_pool_allocator.sv */
`timescale 1ns / 1ps

// channel   direction  handshake                      payload
// request   in         in_valid_i / in_ready_o        op_i, slot_index_i
// result    out        out_valid_o / out_ready_i      status_o, result_index_o, used_count_o
// config    in         psel, penable, pwrite, pready  paddr, pwdata, prdata (pool_size at 0x0)
//
// allocate, free and reinit are accepted, then committed with the link and used-bit
// ram reads in hand. a search reads one used bit per cycle from the used-bit ram,
// starting at the slot given with the request and walking upward up to and including the
// first used slot or the fresh-region mark. reset needs no clearing pass: a mark of slots
// handed out since the last reinit stands in for the default links and clear used bits.
// requests are taken while a result waits; a request's commit waits until the output
// register frees up.

module free_list_pool_allocator #(
  parameter int unsigned MAX_SLOTS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fla_pkg::PADDR_W-1:0]   paddr,
  input  logic [fla_pkg::PDATA_W-1:0]   pwdata,
  output logic [fla_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [fla_pkg::OP_W-1:0]      op_i,
  input  logic [fla_pkg::IDX_W-1:0]     slot_index_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [fla_pkg::ST_W-1:0]      status_o,
  output logic [fla_pkg::IDX_W-1:0]     result_index_o,
  output logic [fla_pkg::CNT_W-1:0]     used_count_o
);

  logic [fla_pkg::CNT_W-1:0] pool_size_q, pool_size_d;
  logic                      reg_sel;
  logic                      reg_wr;
  fla_pkg::op_e              op;
  fla_pkg::cmd_t             cmd;
  fla_pkg::sts_t             sts;
  fla_pkg::status_e          status;

  // register decode, word address only
  assign reg_sel = paddr[fla_pkg::PADDR_W-1] == fla_pkg::REG_POOL_SIZE;
  assign reg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign pready  = 1'b1;

  assign pool_size_d = reg_wr ? pwdata[fla_pkg::CNT_W-1:0] : pool_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_size_q <= fla_pkg::POOL_SIZE_RST;
    end else begin
      pool_size_q <= pool_size_d;
    end
  end

  // read back; unmapped words read zero
  assign prdata = reg_sel ? fla_pkg::PDATA_W'(pool_size_q) : '0;

  assign op = fla_pkg::op_e'(op_i);

  // sequencer: idle, commit, search walk, search result
  fla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  // free list, used bits, counters and output register
  fla_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .op_i           (op),
    .slot_index_i   (slot_index_i),
    .pool_size_i    (pool_size_q),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status),
    .result_index_o (result_index_o),
    .used_count_o   (used_count_o)
  );

  assign status_o = status;

endmodule

/* hdl/fla_ram.sv */
`timescale 1ns / 1ps

module fla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/fla_ctrl.sv */
`timescale 1ns / 1ps

module fla_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  fla_pkg::op_e  op_i,
  input  fla_pkg::sts_t sts_i,
  output logic          in_ready_o,
  output fla_pkg::cmd_t cmd_o
);

  fla_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fla_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fla_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = (op_i == fla_pkg::OP_FIND) ? fla_pkg::S_SCAN : fla_pkg::S_EXEC;
        end
      end
      fla_pkg::S_EXEC: begin
        if (sts_i.out_free) begin
          state_d = fla_pkg::S_IDLE;
        end
      end
      fla_pkg::S_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = fla_pkg::S_SDONE;
        end
      end
      fla_pkg::S_SDONE: begin
        if (sts_i.out_free) begin
          state_d = fla_pkg::S_IDLE;
        end
      end
      default: state_d = fla_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    in_ready_o       = 1'b0;
    cmd_o.accept     = 1'b0;
    cmd_o.commit     = 1'b0;
    cmd_o.scan_run   = 1'b0;
    cmd_o.load_srch  = 1'b0;
    cmd_o.rd_sel     = fla_pkg::RD_HELD;
    case (state_q)
      fla_pkg::S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        cmd_o.rd_sel = fla_pkg::RD_INPUT;
      end
      fla_pkg::S_EXEC: begin
        cmd_o.commit = sts_i.out_free;
      end
      fla_pkg::S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        cmd_o.rd_sel   = fla_pkg::RD_NEXT;
      end
      fla_pkg::S_SDONE: begin
        cmd_o.load_srch = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

/* hdl/fla_dp.sv */
`timescale 1ns / 1ps

module fla_dp #(
  parameter int unsigned MAX_SLOTS = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fla_pkg::cmd_t               cmd_i,
  output fla_pkg::sts_t               sts_o,
  input  fla_pkg::op_e                op_i,
  input  logic [fla_pkg::IDX_W-1:0]   slot_index_i,
  input  logic [fla_pkg::CNT_W-1:0]   pool_size_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output fla_pkg::status_e            status_o,
  output logic [fla_pkg::IDX_W-1:0]   result_index_o,
  output logic [fla_pkg::CNT_W-1:0]   used_count_o
);

  localparam int unsigned AW = $clog2(MAX_SLOTS);
  localparam int unsigned LW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned CW = (LW > fla_pkg::CNT_W) ? LW : fla_pkg::CNT_W;
  localparam int unsigned RST_CAP =
    (MAX_SLOTS < int'(fla_pkg::POOL_SIZE_RST)) ? MAX_SLOTS : int'(fla_pkg::POOL_SIZE_RST);

  // pool state; hwm_q marks how far the fresh region has been handed out
  logic [LW-1:0] cap_q, cap_d;
  logic [LW-1:0] count_q, count_d;
  logic [LW-1:0] head_q, head_d;
  logic [LW-1:0] hwm_q, hwm_d;

  // request and search registers
  fla_pkg::op_e  op_q, op_d;
  logic [CW-1:0] cur_q, cur_d;
  logic          found_q, found_d;

  // output register
  logic                      out_valid_q, out_valid_d;
  fla_pkg::status_e          out_status_q, out_status_d;
  logic [fla_pkg::IDX_W-1:0] out_index_q, out_index_d;
  logic [fla_pkg::CNT_W-1:0] out_used_q, out_used_d;

  // ram ports
  logic          link_we;
  logic [LW-1:0] link_rdata;
  logic          used_we;
  logic [AW-1:0] used_waddr;
  logic          used_wdata;
  logic [AW-1:0] used_raddr;
  logic          used_rdata;

  logic [CW-1:0]             in_ext;
  logic [CW-1:0]             cur_inc;
  logic [CW-1:0]             psz_ext;
  logic [LW-1:0]             psz_clamp;
  logic                      cur_below;
  logic                      head_fresh;
  logic                      alloc_ok;
  logic                      free_ok;
  logic                      out_load;
  fla_pkg::status_e          res_status;
  logic [fla_pkg::IDX_W-1:0] res_index;

  fla_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_SLOTS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (cur_q[AW-1:0]),
    .wdata_i (head_q),
    .raddr_i (head_q[AW-1:0]),
    .rdata_o (link_rdata)
  );

  fla_ram #(
    .WIDTH (1),
    .DEPTH (MAX_SLOTS)
  ) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (used_we),
    .waddr_i (used_waddr),
    .wdata_i (used_wdata),
    .raddr_i (used_raddr),
    .rdata_o (used_rdata)
  );

  assign in_ext     = CW'(slot_index_i);
  assign cur_inc    = cur_q + 1'b1;
  assign cur_below  = cur_q < CW'(hwm_q);
  assign head_fresh = head_q >= hwm_q;
  assign alloc_ok   = (count_q != '0) && (head_q < cap_q);
  assign free_ok    = cur_below && used_rdata;

  // pool size limited to one slot at least and the memory depth at most
  assign psz_ext = CW'(pool_size_i);
  always_comb begin
    if (psz_ext == '0) begin
      psz_clamp = LW'(1);
    end else if (psz_ext > CW'(MAX_SLOTS)) begin
      psz_clamp = LW'(MAX_SLOTS);
    end else begin
      psz_clamp = LW'(psz_ext);
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      fla_pkg::RD_INPUT: used_raddr = in_ext[AW-1:0];
      fla_pkg::RD_HELD:  used_raddr = cur_q[AW-1:0];
      fla_pkg::RD_NEXT:  used_raddr = cur_inc[AW-1:0];
      default:           used_raddr = cur_q[AW-1:0];
    endcase
  end

  // commit of allocate, free and reinit
  always_comb begin
    cap_d      = cap_q;
    count_d    = count_q;
    head_d     = head_q;
    hwm_d      = hwm_q;
    link_we    = 1'b0;
    used_we    = 1'b0;
    used_waddr = head_q[AW-1:0];
    used_wdata = 1'b0;
    res_status = fla_pkg::ST_OK;
    res_index  = '0;
    if (cmd_i.commit) begin
      case (op_q)
        fla_pkg::OP_ALLOC: begin
          if (alloc_ok) begin
            res_index  = fla_pkg::IDX_W'(head_q);
            used_we    = 1'b1;
            used_wdata = 1'b1;
            count_d    = count_q - 1'b1;
            // slots past the mark were never relinked and chain in order
            if (head_fresh) begin
              head_d = head_q + 1'b1;
              hwm_d  = hwm_q + 1'b1;
            end else begin
              head_d = link_rdata;
            end
          end else begin
            res_status = fla_pkg::ST_EMPTY;
          end
        end
        fla_pkg::OP_FREE: begin
          if (free_ok) begin
            link_we    = 1'b1;
            used_we    = 1'b1;
            used_waddr = cur_q[AW-1:0];
            head_d     = LW'(cur_q);
            count_d    = count_q + 1'b1;
          end else begin
            res_status = fla_pkg::ST_BAD_FREE;
          end
        end
        fla_pkg::OP_REINIT: begin
          cap_d   = psz_clamp;
          count_d = psz_clamp;
          head_d  = '0;
          hwm_d   = '0;
        end
        default: begin
          res_status = fla_pkg::ST_OK;
        end
      endcase
    end
  end

  // request latch and search walk
  always_comb begin
    op_d    = op_q;
    cur_d   = cur_q;
    found_d = found_q;
    if (cmd_i.accept) begin
      op_d  = op_i;
      cur_d = in_ext;
    end else if (cmd_i.scan_run) begin
      if (sts_o.scan_done) begin
        found_d = cur_below && used_rdata;
      end else begin
        cur_d = cur_inc;
      end
    end
  end

  assign sts_o.scan_done = !cur_below || used_rdata;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_load = cmd_i.commit || cmd_i.load_srch;

  always_comb begin
    out_status_d = out_status_q;
    out_index_d  = out_index_q;
    out_used_d   = out_used_q;
    if (cmd_i.commit) begin
      out_status_d = res_status;
      out_index_d  = res_index;
      out_used_d   = fla_pkg::CNT_W'(cap_d - count_d);
    end else if (cmd_i.load_srch) begin
      out_status_d = found_q ? fla_pkg::ST_OK : fla_pkg::ST_NOT_FOUND;
      out_index_d  = found_q ? fla_pkg::IDX_W'(cur_q) : '0;
      out_used_d   = fla_pkg::CNT_W'(cap_q - count_q);
    end
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= LW'(RST_CAP);
      count_q     <= LW'(RST_CAP);
      head_q      <= '0;
      hwm_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cap_q       <= cap_d;
      count_q     <= count_d;
      head_q      <= head_d;
      hwm_q       <= hwm_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    cur_q        <= cur_d;
    found_q      <= found_d;
    out_status_q <= out_status_d;
    out_index_q  <= out_index_d;
    out_used_q   <= out_used_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign result_index_o = out_index_q;
  assign used_count_o   = out_used_q;

endmodule
